// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ccq_pkg.sv =====
// Constants, types and helpers for the circle containment query block
`default_nettype none

package ccq_pkg;

    localparam int MAX_CIRCLES_DEF = 8;
    localparam int INDEX_REACH     = 8;
    localparam int IDX_W           = 3;
    localparam int CNT_W           = 4;
    localparam int COORD_W         = 16;
    localparam int RAD_W           = 24;
    localparam int RAD_FRAC        = 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RAD_W-1:0]   r;
    } entry_t;

    // Index of the lowest set bit, zero when none is set
    function automatic logic [IDX_W-1:0] lowest_index(input logic [INDEX_REACH-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = INDEX_REACH - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/circle_containment_query_top.sv =====
// Circle containment query: circle table in a synchronous RAM, scan pipeline and result output
//
// A load transfer writes one circle (centre and radius, 8 fraction bits) into the table
// and gives no result; loads to an entry at or beyond MAX_CIRCLES are dropped.
// A query transfer walks entries 0 to n-1, n being circle_count limited to MAX_CIRCLES and
// to 8, through the table's single read port at one entry per cycle; the results then
// leave the output register at one per cycle while out_ready is high: each containing
// circle in ascending order, or one result with found low when none contains the point,
// the final one marked by last. A new transfer is taken in the cycle after the final
// result leaves. Table entries have no reset and must be loaded before use; the user
// must write circle_count through cfg_wr_en only while the block is idle, as the block
// itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module circle_containment_query_top #(
    parameter int MAX_CIRCLES = ccq_pkg::MAX_CIRCLES_DEF
) (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    input  wire  logic [ccq_pkg::CNT_W-1:0]         cfg_wr_data,
    input  wire  logic                              cfg_wr_en,
    input  wire  logic                              in_valid,
    output logic                                    in_ready,
    input  wire  logic                              operation,
    input  wire  logic [ccq_pkg::IDX_W-1:0]         entry_index,
    input  wire  logic signed [ccq_pkg::COORD_W-1:0] pos_x,
    input  wire  logic signed [ccq_pkg::COORD_W-1:0] pos_y,
    input  wire  logic [ccq_pkg::RAD_W-1:0]         radius,
    output logic                                    out_valid,
    input  wire  logic                              out_ready,
    output logic [ccq_pkg::IDX_W-1:0]               circle_index,
    output logic                                    found,
    output logic                                    last,
    output logic [ccq_pkg::IDX_W-1:0]               widest_index
);
    import ccq_pkg::*;

    localparam int ADDR_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int SCAN_N = (MAX_CIRCLES < INDEX_REACH) ? MAX_CIRCLES : INDEX_REACH;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int R2_W   = 2 * RAD_W;
    localparam int SHIFT  = 2 * RAD_FRAC;
    localparam int CMP_W  = D2_W + SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    circle_count_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                s1_vld_reg;
    logic                s2_vld_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [IDX_W-1:0]    s2_idx_reg;
    logic [SCAN_N-1:0]   mask_reg;
    logic [RAD_W-1:0]    best_r_reg;
    logic [IDX_W-1:0]    widest_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    circle_index_reg;
    logic                found_reg;
    logic                last_reg;

    // Table RAM and datapath registers
    entry_t              mem [MAX_CIRCLES];
    entry_t              rd_data_reg;
    logic [COORD_W-1:0]  px_reg;
    logic [COORD_W-1:0]  py_reg;
    logic [SQ_W-1:0]     dx2_reg;
    logic [SQ_W-1:0]     dy2_reg;
    logic [R2_W-1:0]     r2_reg;

    logic                in_xfer;
    logic                wr_en;
    logic                rd_en;
    logic                scan_done;
    logic [CNT_W-1:0]    n_use;
    logic [DIFF_W-1:0]   dx;
    logic [DIFF_W-1:0]   dy;
    logic [DIFF_W-1:0]   dx_neg;
    logic [DIFF_W-1:0]   dy_neg;
    logic [COORD_W-1:0]  ax;
    logic [COORD_W-1:0]  ay;
    logic [D2_W-1:0]     d2;
    logic                hit;
    logic [INDEX_REACH-1:0] hit8;
    logic [INDEX_REACH-1:0] mask8;
    logic [INDEX_REACH-1:0] pick8;
    logic [INDEX_REACH-1:0] rest8;
    logic [IDX_W-1:0]    next_idx;
    logic                next_found;
    logic                next_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign wr_en    = in_xfer && (operation == OP_LOAD) && (int'(entry_index) < MAX_CIRCLES);
    assign rd_en    = (state_reg == ST_SCAN) && (rd_cnt_reg < n_reg);
    assign scan_done = (state_reg == ST_SCAN) && (rd_cnt_reg == n_reg)
                       && !s1_vld_reg && !s2_vld_reg;
    assign n_use    = (circle_count_reg > CNT_W'(SCAN_N)) ? CNT_W'(SCAN_N) : circle_count_reg;

    // Stage one: distances from the registered table entry
    assign dx     = {px_reg[COORD_W-1], px_reg} - {rd_data_reg.x[COORD_W-1], rd_data_reg.x};
    assign dy     = {py_reg[COORD_W-1], py_reg} - {rd_data_reg.y[COORD_W-1], rd_data_reg.y};
    assign dx_neg = (~dx) + DIFF_W'(1);
    assign dy_neg = (~dy) + DIFF_W'(1);
    assign ax     = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
    assign ay     = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];

    // Stage two: radius squared against scaled distance squared
    assign d2   = D2_W'(dx2_reg) + D2_W'(dy2_reg);
    assign hit  = CMP_W'(r2_reg) > (CMP_W'(d2) << SHIFT);
    assign hit8 = hit ? (INDEX_REACH'(1) << s2_idx_reg) : '0;

    // Next result from the match mask
    assign mask8      = INDEX_REACH'(mask_reg);
    assign pick8      = mask8 & ((~mask8) + INDEX_REACH'(1));
    assign rest8      = mask8 & ~pick8;
    assign next_idx   = lowest_index(mask8);
    assign next_found = |mask8;
    assign next_last  = (rest8 == '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ADDR_W'(entry_index)] <= '{x: pos_x, y: pos_y, r: radius};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ADDR_W'(rd_cnt_reg[IDX_W-1:0])];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (operation == OP_QUERY))
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
        dx2_reg <= SQ_W'(ax) * SQ_W'(ax);
        dy2_reg <= SQ_W'(ay) * SQ_W'(ay);
        r2_reg  <= R2_W'(rd_data_reg.r) * R2_W'(rd_data_reg.r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            circle_count_reg <= '0;
            n_reg            <= '0;
            rd_cnt_reg       <= '0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            s1_idx_reg       <= '0;
            s2_idx_reg       <= '0;
            mask_reg         <= '0;
            best_r_reg       <= '0;
            widest_reg       <= '0;
            out_valid_reg    <= 1'b0;
            circle_index_reg <= '0;
            found_reg        <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= rd_en;
            s1_idx_reg <= rd_cnt_reg[IDX_W-1:0];
            s2_vld_reg <= s1_vld_reg;
            s2_idx_reg <= s1_idx_reg;
            if (cfg_wr_en)
            begin
                circle_count_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && (operation == OP_QUERY))
                    begin
                        state_reg  <= ST_SCAN;
                        n_reg      <= n_use;
                        rd_cnt_reg <= '0;
                        mask_reg   <= '0;
                        widest_reg <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    end
                    // Keep the first entry with the largest radius
                    if (s1_vld_reg && ((s1_idx_reg == '0) || (rd_data_reg.r > best_r_reg)))
                    begin
                        best_r_reg <= rd_data_reg.r;
                        widest_reg <= s1_idx_reg;
                    end
                    if (s2_vld_reg)
                    begin
                        mask_reg <= mask_reg | SCAN_N'(hit8);
                    end
                    if (scan_done)
                    begin
                        state_reg        <= ST_EMIT;
                        out_valid_reg    <= 1'b1;
                        circle_index_reg <= next_idx;
                        found_reg        <= next_found;
                        last_reg         <= next_last;
                        mask_reg         <= SCAN_N'(rest8);
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (last_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            circle_index_reg <= next_idx;
                            found_reg        <= next_found;
                            last_reg         <= next_last;
                            mask_reg         <= SCAN_N'(rest8);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign circle_index = circle_index_reg;
    assign found        = found_reg;
    assign last         = last_reg;
    assign widest_index = widest_reg;

    `ASSERT_SAME(a_no_input_while_output, clk, rst_n, in_ready, !out_valid_reg,
        "input accepted while a result is pending")
    `ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_valid && out_ready && last, in_ready,
        "block not idle after final result")
    `ASSERT_SAME(a_miss_is_last, clk, rst_n, out_valid && !found, last,
        "empty result not marked last")
    `ASSERT_SAME(a_read_in_range, clk, rst_n, rd_en, int'(rd_cnt_reg) < SCAN_N,
        "table read beyond entries in use")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the circle containment query block
`timescale 1ns / 100ps

module tb;
    import ccq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 16;
    localparam int PHASE_ITEMS  = 30;
    localparam int PHASE_TOTAL  = 7;

    typedef struct {
        logic                      op;
        logic [IDX_W-1:0]          slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RAD_W-1:0]          r;
    } circle_req_t;

    typedef struct {
        logic [IDX_W-1:0] circle_index;
        logic             found;
        logic             last;
        logic [IDX_W-1:0] widest_index;
    } hit_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic [CNT_W-1:0]          cfg_wr_data = '0;
    logic                      cfg_wr_en = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      operation = OP_LOAD;
    logic [IDX_W-1:0]          entry_index = '0;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic [RAD_W-1:0]          radius = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [IDX_W-1:0]          circle_index;
    logic                      found;
    logic                      last;
    logic [IDX_W-1:0]          widest_index;

    // Circle table as seen at the block's input (on transfer) and as planned by stimulus
    logic signed [COORD_W-1:0] table_cx   [MAX_CIRCLES_DEF];
    logic signed [COORD_W-1:0] table_cy   [MAX_CIRCLES_DEF];
    logic [RAD_W-1:0]          table_rad  [MAX_CIRCLES_DEF];
    logic signed [COORD_W-1:0] plan_cx    [MAX_CIRCLES_DEF];
    logic signed [COORD_W-1:0] plan_cy    [MAX_CIRCLES_DEF];
    logic [RAD_W-1:0]          plan_rad   [MAX_CIRCLES_DEF];
    logic [CNT_W-1:0]          count_in_use = '0;

    circle_req_t circle_requests [$];
    hit_t        expected_hits   [$];
    circle_req_t next_req;
    hit_t        seen_hit;
    hit_t        want_hit;

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;
    int unsigned mismatch_total = 0;
    int unsigned cycle_count = 0;
    int unsigned phase_count [PHASE_TOTAL] = '{8, 1, 15, 5, 0, 3, 8};

    circle_containment_query_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_data  (cfg_wr_data),
        .cfg_wr_en    (cfg_wr_en),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .entry_index  (entry_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .radius       (radius),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .circle_index (circle_index),
        .found        (found),
        .last         (last),
        .widest_index (widest_index)
    );

    always #CLK_HALF clk = ~clk;

    function automatic void store_circle(input circle_req_t req);
        table_cx[req.slot]  = req.x;
        table_cy[req.slot]  = req.y;
        table_rad[req.slot] = req.r;
    endfunction

    // Walk the entries in use and queue every containing circle, or one empty result when none, last one marked
    function automatic void compute_hits(input logic signed [COORD_W-1:0] qx,
                                         input logic signed [COORD_W-1:0] qy);
        int unsigned       in_use;
        int unsigned       widest;
        bit                have_hit;
        longint signed     dx;
        longint signed     dy;
        longint unsigned   d2;
        longint unsigned   rr;
        hit_t              held;
        in_use = 32'(count_in_use);
        if (in_use > MAX_CIRCLES_DEF)
            in_use = MAX_CIRCLES_DEF;
        if (in_use > INDEX_REACH)
            in_use = INDEX_REACH;
        widest = 0;
        for (int i = 1; i < in_use; i++)
        begin
            if (table_rad[i] > table_rad[widest])
                widest = i;
        end
        have_hit = 1'b0;
        held.circle_index = '0;
        held.found = 1'b0;
        held.last = 1'b0;
        held.widest_index = IDX_W'(widest);
        for (int i = 0; i < in_use; i++)
        begin
            dx = longint'(qx) - longint'(table_cx[i]);
            dy = longint'(qy) - longint'(table_cy[i]);
            d2 = dx * dx + dy * dy;
            rr = longint'(table_rad[i]) * longint'(table_rad[i]);
            if (rr > (d2 << 16))
            begin
                if (have_hit)
                    expected_hits.push_back(held);
                held.circle_index = IDX_W'(i);
                held.found = 1'b1;
                have_hit = 1'b1;
            end
        end
        held.last = 1'b1;
        expected_hits.push_back(held);
    endfunction

    function automatic void queue_load(input logic [IDX_W-1:0] slot,
                                       input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic [RAD_W-1:0] r);
        circle_req_t req;
        req.op = OP_LOAD;
        req.slot = slot;
        req.x = x;
        req.y = y;
        req.r = r;
        plan_cx[slot] = x;
        plan_cy[slot] = y;
        plan_rad[slot] = r;
        circle_requests.push_back(req);
    endfunction

    function automatic void queue_query(input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y);
        circle_req_t req;
        req.op = OP_QUERY;
        req.slot = IDX_W'($urandom);
        req.x = x;
        req.y = y;
        req.r = RAD_W'($urandom);
        circle_requests.push_back(req);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return COORD_W'(v);
    endfunction

    // Mostly clustered circles and points near a centre, so queries hit several entries
    function automatic void queue_random_item();
        int unsigned sel;
        int unsigned k;
        int unsigned span;
        int          lim;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RAD_W-1:0] r;
        if ($urandom_range(0, 9) < 3)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            else
            begin
                x = COORD_W'(int'($urandom_range(0, 4000)) - 2000);
                y = COORD_W'(int'($urandom_range(0, 4000)) - 2000);
            end
            sel = $urandom_range(0, 9);
            if (sel == 0)
                r = '1;
            else if (sel == 1)
                r = plan_rad[$urandom_range(0, MAX_CIRCLES_DEF - 1)];
            else if (sel == 2)
                r = '0;
            else
                r = RAD_W'($urandom) & RAD_W'((32'd1 << $urandom_range(1, RAD_W)) - 1);
            queue_load(IDX_W'($urandom_range(0, MAX_CIRCLES_DEF - 1)), x, y, r);
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            span = (count_in_use == '0) ? MAX_CIRCLES_DEF :
                   (int'(count_in_use) > MAX_CIRCLES_DEF) ? MAX_CIRCLES_DEF :
                   int'(count_in_use);
            k = $urandom_range(0, span - 1);
            lim = int'(plan_rad[k] >> RAD_FRAC);
            if (lim > 40000)
                lim = 40000;
            lim = lim + 2;
            x = clamp_coord(int'(plan_cx[k]) + int'($urandom_range(0, 2 * lim)) - lim);
            y = clamp_coord(int'(plan_cy[k]) + int'($urandom_range(0, 2 * lim)) - lim);
            queue_query(x, y);
        end
        else
            queue_query(COORD_W'($urandom), COORD_W'($urandom));
    endfunction

    // Wait until the input side is empty and every result has arrived, then let the block drain
    task automatic settle();
        do
            @(negedge clk);
        while (circle_requests.size() != 0 || in_valid || expected_hits.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        count_in_use = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Sender: bursts of transfers with random gaps in between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= OP_LOAD;
            entry_index <= '0;
            pos_x <= '0;
            pos_y <= '0;
            radius <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                next_req.op = operation;
                next_req.slot = entry_index;
                next_req.x = pos_x;
                next_req.y = pos_y;
                next_req.r = radius;
                if (operation == OP_QUERY)
                    compute_hits(pos_x, pos_y);
                else
                    store_circle(next_req);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (circle_requests.size() != 0)
                begin
                    next_req = circle_requests.pop_front();
                    operation <= next_req.op;
                    entry_index <= next_req.slot;
                    pos_x <= next_req.x;
                    pos_y <= next_req.y;
                    radius <= next_req.r;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each transfer, stall on a pattern that is redrawn at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_hit.circle_index = circle_index;
                seen_hit.found = found;
                seen_hit.last = last;
                seen_hit.widest_index = widest_index;
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected result: circle_index %0d found %0b last %0b widest %0d",
                           seen_hit.circle_index, seen_hit.found, seen_hit.last,
                           seen_hit.widest_index);
                    mismatch_total++;
                end
                else
                begin
                    want_hit = expected_hits.pop_front();
                    if (seen_hit.circle_index !== want_hit.circle_index)
                    begin
                        $error("circle_index: expected %0d, actual %0d",
                               want_hit.circle_index, seen_hit.circle_index);
                        mismatch_total++;
                    end
                    if (seen_hit.found !== want_hit.found)
                    begin
                        $error("found: expected %0b, actual %0b", want_hit.found, seen_hit.found);
                        mismatch_total++;
                    end
                    if (seen_hit.last !== want_hit.last)
                    begin
                        $error("last: expected %0b, actual %0b", want_hit.last, seen_hit.last);
                        mismatch_total++;
                    end
                    if (seen_hit.widest_index !== want_hit.widest_index)
                    begin
                        $error("widest_index: expected %0d, actual %0d",
                               want_hit.widest_index, seen_hit.widest_index);
                        mismatch_total++;
                    end
                end
            end
            if (stall_span == 0)
            begin
                stall_span = 64;
                stall_mode = $urandom_range(0, 2);
            end
            stall_span--;
            if (stall_mode == 0)
                out_ready <= 1'b1;
            else if (stall_mode == 1)
                out_ready <= 1'($urandom_range(0, 1));
            else
                out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("circle_containment_query_top verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_CIRCLES_DEF; i++)
        begin
            table_cx[i] = '0;
            table_cy[i] = '0;
            table_rad[i] = '0;
            plan_cx[i] = '0;
            plan_cy[i] = '0;
            plan_rad[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // No entries in use: one empty result, widest 0
        queue_query(16'sd0, 16'sd0);
        queue_query(16'sh8000, 16'sh7FFF);
        // Fill the whole table; entries 0 and 6 tie on the largest radius
        queue_load(3'd0, 16'sh8000, 16'sh8000, 24'hFFFFFF);
        queue_load(3'd1, 16'sh7FFF, 16'sh7FFF, 24'h000000);
        queue_load(3'd2, 16'sd0, 16'sd0, 24'h000100);
        queue_load(3'd3, 16'sd0, 16'sd0, 24'h000040);
        queue_load(3'd4, 16'sd100, -16'sd100, 24'h000A00);
        queue_load(3'd5, -16'sd1, 16'sd1, 24'h000180);
        queue_load(3'd6, 16'sh7FFF, 16'sh8000, 24'hFFFFFF);
        queue_load(3'd7, 16'sd5, 16'sd5, 24'h001000);
        settle();

        write_count(4'd8);
        queue_query(16'sd0, 16'sd0);
        // Exactly on the unit circle's edge: not contained
        queue_query(16'sd1, 16'sd0);
        // Far corner: only entry 6 contains it, entry 0 does not reach it
        queue_query(16'sh7FFF, 16'sh7FFF);
        queue_query(16'sh8000, 16'sh7FFF);
        queue_query(16'sh7FFF, 16'sh8000);
        queue_query(16'sh8000, 16'sh8000);
        settle();

        for (int p = 0; p < PHASE_TOTAL; p++)
        begin
            write_count(CNT_W'(phase_count[p]));
            for (int j = 0; j < PHASE_ITEMS; j++)
                queue_random_item();
            settle();
        end

        if (mismatch_total == 0 && expected_hits.size() == 0)
            $display("circle_containment_query_top verification clean");
        else
            $display("circle_containment_query_top verification failed");
        $finish;
    end

endmodule
